FILE: hw/rtl/sfs_pkg.sv
// Shared types, sizes and command codes for the SPI NOR flash target.
package sfs_pkg;

	// Memory geometry, all powers of two
	localparam int unsigned MEM_BYTES       = 1048576;
	localparam int unsigned SECTOR_BYTES    = 65536;
	localparam int unsigned SUBSECTOR_BYTES = 4096;
	localparam int unsigned PAGE_BYTES      = 256;

	localparam int unsigned ADDR_W = $clog2(MEM_BYTES);
	localparam int unsigned PAGE_W = $clog2(PAGE_BYTES);

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [PAGE_W-1:0] page_off_t;

	localparam addr_t ADDR_ALL       = addr_t'(MEM_BYTES - 1);
	localparam addr_t SECTOR_MASK    = addr_t'(SECTOR_BYTES - 1);
	localparam addr_t SUBSECTOR_MASK = addr_t'(SUBSECTOR_BYTES - 1);

	// Command bytes
	localparam logic [7:0] CMD_WREN  = 8'h06;
	localparam logic [7:0] CMD_RDID  = 8'h9F;
	localparam logic [7:0] CMD_RDSR  = 8'h05;
	localparam logic [7:0] CMD_READ  = 8'h03;
	localparam logic [7:0] CMD_FREAD = 8'h0B;
	localparam logic [7:0] CMD_PP    = 8'h02;
	localparam logic [7:0] CMD_SE    = 8'hD8;
	localparam logic [7:0] CMD_BE    = 8'hC7;
	localparam logic [7:0] CMD_SSE   = 8'h20;

	localparam logic [7:0] BYTE_IDLE = 8'hFF;
	localparam logic [7:0] STATUS_VALUE = 8'h00;

	// Request opcodes
	localparam logic OP_EXCHANGE = 1'b0;
	localparam logic OP_SELECT   = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] REG_MANUFACTURER_ID = 2'd0;
	localparam logic [1:0] REG_MEMORY_TYPE     = 2'd1;
	localparam logic [1:0] REG_CAPACITY_CODE   = 2'd2;

	// Queue between front and back
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		K_BYTE      = 2'd0,
		K_IDLE_BYTE = 2'd1,
		K_DESELECT  = 2'd2
	} item_kind_t;

	typedef struct packed {
		item_kind_t kind;
		logic [7:0] data;
	} q_entry_t;

	typedef struct packed {
		logic [7:0] manufacturer_id;
		logic [7:0] memory_type;
		logic [7:0] capacity_code;
	} id_regs_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

FILE: hw/rtl/sfs_queue.sv
// Short request queue between the classifier and the command engine.
module sfs_queue
	import sfs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	input  logic     pop,
	output logic     full,
	output logic     valid,
	output q_entry_t head
);

	q_entry_t             entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	assign full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign valid = (count_q != '0);
	assign head  = entry_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/sfs_front.sv
// Front end: takes requests, tracks chip select and classifies each request.
module sfs_front
	import sfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       opcode,
	input  logic [7:0] tx_byte,
	input  logic       select_level,
	input  back_stat_t stat,
	input  logic       q_full,
	output logic       q_push,
	output q_entry_t   q_entry
);

	logic chip_sel_q;
	logic accept;

	assign in_stall = q_full || stat.clearing;
	assign accept   = in_valid && !in_stall;

	// Classify: a select assertion only updates the select flag
	always_comb begin
		q_push       = 1'b0;
		q_entry.kind = K_BYTE;
		q_entry.data = tx_byte;
		if (accept) begin
			if (opcode == OP_SELECT) begin
				q_push       = !select_level;
				q_entry.kind = K_DESELECT;
			end else begin
				q_push       = 1'b1;
				q_entry.kind = chip_sel_q ? K_BYTE : K_IDLE_BYTE;
			end
		end
	end

	// Chip select flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_sel_q <= 1'b0;
		end else if (accept && opcode == OP_SELECT) begin
			chip_sel_q <= select_level;
		end
	end

endmodule

FILE: hw/rtl/sfs_back.sv
// Back end: command engine, byte memory with erase sweeps, and result register.
module sfs_back
	import sfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  q_entry_t   q_head,
	output logic       q_pop,
	input  id_regs_t   id_regs,
	output back_stat_t stat,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] rx_byte
);

	typedef enum logic [3:0] {
		B_CLEAR = 4'b0001,
		B_RUN   = 4'b0010,
		B_READ  = 4'b0100,
		B_ERASE = 4'b1000
	} ctrl_t;

	typedef enum logic [18:0] {
		E_IDLE    = 19'b000_0000_0000_0000_0001,
		E_ID1     = 19'b000_0000_0000_0000_0010,
		E_ID2     = 19'b000_0000_0000_0000_0100,
		E_ID3     = 19'b000_0000_0000_0000_1000,
		E_WREN    = 19'b000_0000_0000_0001_0000,
		E_RDSR    = 19'b000_0000_0000_0010_0000,
		E_ER1     = 19'b000_0000_0000_0100_0000,
		E_ER2     = 19'b000_0000_0000_1000_0000,
		E_ER3     = 19'b000_0000_0001_0000_0000,
		E_ERDONE  = 19'b000_0000_0010_0000_0000,
		E_PG1     = 19'b000_0000_0100_0000_0000,
		E_PG2     = 19'b000_0000_1000_0000_0000,
		E_PG3     = 19'b000_0001_0000_0000_0000,
		E_PGDATA  = 19'b000_0010_0000_0000_0000,
		E_RD1     = 19'b000_0100_0000_0000_0000,
		E_RD2     = 19'b000_1000_0000_0000_0000,
		E_RD3     = 19'b001_0000_0000_0000_0000,
		E_RDDUMMY = 19'b010_0000_0000_0000_0000,
		E_RDDATA  = 19'b100_0000_0000_0000_0000
	} eng_t;

	logic [7:0] mem_q [MEM_BYTES];

	ctrl_t      ctrl_q, ctrl_d;
	eng_t       eng_q, eng_d;
	logic       wen_q, wen_d;
	logic [7:0] last_q, last_d;
	addr_t      cur_q, cur_d;
	logic [7:0] reply_q, reply_d;
	addr_t      sweep_addr_q;
	addr_t      sweep_mask_q;
	logic [7:0] rdata_q;
	logic       out_valid_q;
	logic [7:0] rx_q;

	logic       out_free;
	logic [7:0] d;
	logic [23:0] cur24;
	addr_t      addr_hi;
	addr_t      addr_mid;
	addr_t      addr_full;
	addr_t      page_next;
	logic       sweep_done;
	logic       start_erase;
	addr_t      erase_base;
	addr_t      erase_mask;
	logic       rd_issue;
	logic       res_load;
	logic [7:0] res_byte;
	logic       mem_we;
	addr_t      mem_waddr;
	logic [7:0] mem_wdata;

	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = (ctrl_q == B_RUN) && q_valid && out_free;
	assign d         = q_head.data;
	assign out_valid = out_valid_q;
	assign rx_byte   = rx_q;
	assign stat.clearing = (ctrl_q == B_CLEAR);

	// Address byte assembly, most significant byte first
	assign cur24     = 24'(cur_q);
	assign addr_hi   = addr_t'({d, 16'h0000});
	assign addr_mid  = addr_t'(cur24 | {8'h00, d, 8'h00});
	assign addr_full = addr_t'(cur24 | {16'h0000, d});
	// Program address wraps inside its page
	assign page_next = {cur_q[ADDR_W-1:PAGE_W], cur_q[PAGE_W-1:0] + page_off_t'(1)};

	assign sweep_done = ((sweep_addr_q & sweep_mask_q) == sweep_mask_q);

	// Command engine and memory port control
	always_comb begin
		ctrl_d      = ctrl_q;
		eng_d       = eng_q;
		wen_d       = wen_q;
		last_d      = last_q;
		cur_d       = cur_q;
		reply_d     = reply_q;
		start_erase = 1'b0;
		erase_base  = '0;
		erase_mask  = ADDR_ALL;
		rd_issue    = 1'b0;
		res_load    = 1'b0;
		res_byte    = reply_q;
		mem_we      = 1'b0;
		mem_waddr   = sweep_addr_q;
		mem_wdata   = BYTE_IDLE;

		unique case (ctrl_q)
			B_CLEAR, B_ERASE: begin
				mem_we = 1'b1;
				if (sweep_done) begin
					ctrl_d = B_RUN;
				end
			end
			B_READ: begin
				reply_d  = rdata_q;
				res_load = 1'b1;
				res_byte = rdata_q;
				ctrl_d   = B_RUN;
			end
			B_RUN: begin
				if (q_pop) begin
					unique case (q_head.kind)
						K_DESELECT: begin
							eng_d = E_IDLE;
							if (last_q != CMD_WREN) begin
								wen_d = 1'b0;
							end
						end
						K_IDLE_BYTE: begin
							res_load = 1'b1;
							res_byte = BYTE_IDLE;
						end
						K_BYTE: begin
							res_load = 1'b1;
							unique case (eng_q)
								E_IDLE: begin
									last_d  = d;
									reply_d = BYTE_IDLE;
									unique case (d)
										CMD_RDID: eng_d = E_ID1;
										CMD_WREN: begin
											wen_d = 1'b1;
											eng_d = E_WREN;
										end
										CMD_RDSR: eng_d = E_RDSR;
										CMD_SE, CMD_SSE: eng_d = E_ER1;
										CMD_BE: begin
											start_erase = wen_q;
										end
										CMD_PP: eng_d = E_PG1;
										CMD_READ, CMD_FREAD: eng_d = E_RD1;
										default: begin
										end
									endcase
								end
								E_ID1: begin
									reply_d = id_regs.manufacturer_id;
									eng_d   = E_ID2;
								end
								E_ID2: begin
									reply_d = id_regs.memory_type;
									eng_d   = E_ID3;
								end
								E_ID3: begin
									reply_d = id_regs.capacity_code;
									eng_d   = E_IDLE;
								end
								E_WREN: wen_d = 1'b0;
								E_RDSR: begin
									reply_d = STATUS_VALUE;
									eng_d   = E_IDLE;
								end
								E_ER1: begin
									cur_d = addr_hi;
									eng_d = E_ER2;
								end
								E_PG1: begin
									cur_d = addr_hi;
									eng_d = E_PG2;
								end
								E_RD1: begin
									cur_d = addr_hi;
									eng_d = E_RD2;
								end
								E_ER2: begin
									cur_d = addr_mid;
									eng_d = E_ER3;
								end
								E_PG2: begin
									cur_d = addr_mid;
									eng_d = E_PG3;
								end
								E_RD2: begin
									cur_d = addr_mid;
									eng_d = E_RD3;
								end
								E_ER3: begin
									cur_d       = addr_full;
									eng_d       = E_ERDONE;
									start_erase = wen_q;
									if (last_q == CMD_SE) begin
										erase_mask = SECTOR_MASK;
									end else begin
										erase_mask = SUBSECTOR_MASK;
									end
									erase_base = addr_full & ~erase_mask;
								end
								E_ERDONE: begin
								end
								E_PG3: begin
									cur_d = addr_full;
									eng_d = E_PGDATA;
								end
								E_PGDATA: begin
									mem_we    = wen_q;
									mem_waddr = cur_q;
									mem_wdata = d;
									cur_d     = page_next;
								end
								E_RD3: begin
									cur_d = addr_full;
									eng_d = (last_q == CMD_FREAD) ? E_RDDUMMY : E_RDDATA;
								end
								E_RDDUMMY: begin
									reply_d = BYTE_IDLE;
									eng_d   = E_RDDATA;
								end
								E_RDDATA: begin
									// Reply comes from the registered memory read
									rd_issue = 1'b1;
									res_load = 1'b0;
									cur_d    = cur_q + addr_t'(1);
									ctrl_d   = B_READ;
								end
								default: begin
									eng_d   = E_IDLE;
									reply_d = BYTE_IDLE;
								end
							endcase
							res_byte = reply_d;
						end
						default: begin
						end
					endcase
					if (start_erase) begin
						ctrl_d = B_ERASE;
					end
				end
			end
			default: ctrl_d = B_RUN;
		endcase
	end

	// Byte memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rdata_q <= mem_q[cur_q];
		end
	end

	// Engine state and sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q       <= B_CLEAR;
			eng_q        <= E_IDLE;
			wen_q        <= 1'b0;
			last_q       <= BYTE_IDLE;
			cur_q        <= '0;
			reply_q      <= BYTE_IDLE;
			sweep_addr_q <= '0;
			sweep_mask_q <= ADDR_ALL;
		end else begin
			ctrl_q  <= ctrl_d;
			eng_q   <= eng_d;
			wen_q   <= wen_d;
			last_q  <= last_d;
			cur_q   <= cur_d;
			reply_q <= reply_d;
			if (start_erase && q_pop) begin
				sweep_addr_q <= erase_base;
				sweep_mask_q <= erase_mask;
			end else if (mem_we && (ctrl_q == B_CLEAR || ctrl_q == B_ERASE)) begin
				sweep_addr_q <= sweep_addr_q + addr_t'(1);
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rx_q <= res_byte;
		end
	end

endmodule

FILE: hw/rtl/spi_nor_flash_slave.sv
// SPI NOR flash target: ID registers, front classifier, request queue and command engine.
// Replies are registered; a data read first passes through the registered memory read port.
// One request per cycle unless stalled; a data read holds the engine for the memory port.
// Sub-sector, sector and bulk erase hold the engine to sweep 4096, 65536 and 1048576 bytes.
// After reset the whole memory is cleared to 0xFF with in_stall held high.
// Reset returns the ID registers to 0x20, 0x20, 0x14 and the engine to idle, deselected.
module spi_nor_flash_slave
	import sfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       opcode,
	input  logic [7:0] tx_byte,
	input  logic       select_level,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] rx_byte
);

	id_regs_t   id_q;
	back_stat_t stat;
	logic       q_full;
	logic       q_push;
	q_entry_t   q_entry;
	logic       q_pop;
	logic       q_valid;
	q_entry_t   q_head;

	// ID configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q.manufacturer_id <= 8'h20;
			id_q.memory_type     <= 8'h20;
			id_q.capacity_code   <= 8'h14;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MANUFACTURER_ID: id_q.manufacturer_id <= cfg_data;
				REG_MEMORY_TYPE:     id_q.memory_type     <= cfg_data;
				REG_CAPACITY_CODE:   id_q.capacity_code   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sfs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.tx_byte      (tx_byte),
		.select_level (select_level),
		.stat         (stat),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (q_entry)
	);

	sfs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.full       (q_full),
		.valid      (q_valid),
		.head       (q_head)
	);

	sfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.id_regs   (id_q),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.rx_byte   (rx_byte)
	);

endmodule
